@@ rtl/msgpack_transaction_row_parser_top_defines.svh @@
// ---------------------------------------------------------------------------
// MessagePack row parser assertion macros
// Shared checking macros for the row parser. They expect clk and arst_n in
// the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef MSGPACK_TRANSACTION_ROW_PARSER_TOP_DEFINES_SVH
`define MSGPACK_TRANSACTION_ROW_PARSER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MSGP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define MSGP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/msgp_pkg.sv @@
// ---------------------------------------------------------------------------
// MessagePack row parser package
// Parse phases, result layout, byte codes and result helpers shared by the
// parser, the result queue and the top level.
// ---------------------------------------------------------------------------
package msgp_pkg;

	// Field widths.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned ERR_W   = 4;
	localparam int unsigned CFG_W   = 8;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned TDATA_W = 72;
	localparam int unsigned TUSER_W = 5;

	// Result queue depth and level width.
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QPTR_W   = 2;
	localparam int unsigned QLEVEL_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_TAG  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_TYPE = 1'd1;
	localparam logic [CFG_W-1:0] ROW_TAG_RESET  = 8'h13;
	localparam logic [CFG_W-1:0] MSG_TYPE_RESET = 8'h01;

	// Encoding bytes.
	localparam logic [7:0] B_ARR16   = 8'hdc;
	localparam logic [7:0] B_ARR32   = 8'hdd;
	localparam logic [7:0] B_NIL     = 8'hc0;
	localparam logic [7:0] B_EXT16   = 8'hd8;
	localparam logic [7:0] B_ID_KIND = 8'h01;
	localparam logic [7:0] B_UINT64  = 8'hcf;
	localparam logic [7:0] B_INT64   = 8'hd3;
	localparam logic [7:0] B_UINT32  = 8'hce;
	localparam logic [7:0] B_INT32   = 8'hd2;
	localparam logic [7:0] B_STR8    = 8'hd9;
	localparam logic [7:0] B_BIN8    = 8'hc4;
	localparam logic [3:0] NIB_FIXARR = 4'h9;
	localparam logic [2:0] TOP_FIXSTR = 3'b101;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_FOLLOWS  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_NOTE_LEN = 3'd5;
	localparam logic [KIND_W-1:0] KIND_NOTE     = 3'd6;
	localparam logic [KIND_W-1:0] KIND_STATUS   = 3'd7;

	// Status codes.
	localparam logic [ERR_W-1:0] ERR_OK        = 4'd0;
	localparam logic [ERR_W-1:0] ERR_ARR_HDR   = 4'd1;
	localparam logic [ERR_W-1:0] ERR_ENVELOPE  = 4'd2;
	localparam logic [ERR_W-1:0] ERR_TYPE      = 4'd3;
	localparam logic [ERR_W-1:0] ERR_NO_ROWS   = 4'd4;
	localparam logic [ERR_W-1:0] ERR_FEW_FLDS  = 4'd5;
	localparam logic [ERR_W-1:0] ERR_ROW_TAG   = 4'd6;
	localparam logic [ERR_W-1:0] ERR_ID_TAG    = 4'd7;
	localparam logic [ERR_W-1:0] ERR_ID_KIND   = 4'd8;
	localparam logic [ERR_W-1:0] ERR_INT_TAG   = 4'd9;
	localparam logic [ERR_W-1:0] ERR_STR_TAG   = 4'd10;
	localparam logic [ERR_W-1:0] ERR_TRUNCATED = 4'd11;

	// Row field positions.
	localparam logic [3:0] FIELD_LAST_ID = 4'd4;
	localparam logic [3:0] FIELD_FOLLOWS = 4'd5;
	localparam logic [3:0] FIELD_LIMIT   = 4'd7;

	// Minimum counts.
	localparam logic [31:0] ENV_COUNT      = 32'd2;
	localparam logic [31:0] MIN_ROW_FIELDS = 32'd3;

	// Parse phases.
	typedef enum logic [4:0] {
		PH_ENV_HDR, PH_ENV_LEN, PH_TYPE_TAG, PH_TYPE_VAL, PH_ROWS_HDR, PH_ROWS_LEN,
		PH_ROW_HDR, PH_ROW_LEN, PH_TAG_TAG, PH_TAG_VAL, PH_ID_TAG, PH_ID_KIND,
		PH_ID_BYTES, PH_FOL_TAG, PH_FOL_VAL, PH_STR_TAG, PH_STR_LEN, PH_STR_BYTES,
		PH_DONE, PH_ERR
	} phase_t;

	// One result item.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               half;
		logic               nil;
		logic [ERR_W-1:0]   err;
		logic               last;
	} res_t;

	// Results produced by one byte, handed from the parser to the queue.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic res_t mk_res(input logic [KIND_W-1:0] kind,
			input logic [VALUE_W-1:0] value, input logic half, input logic nil,
			input logic [ERR_W-1:0] err);
		res_t r;
		r.kind  = kind;
		r.value = value;
		r.half  = half;
		r.nil   = nil;
		r.err   = err;
		r.last  = 1'b0;
		return r;
	endfunction

endpackage

@@ rtl/msgp_parse.sv @@
// ---------------------------------------------------------------------------
// MessagePack row parser byte stage
// Registers each input byte, then advances the parse state by one byte and
// produces up to two results for the result queue.
// ---------------------------------------------------------------------------
module msgp_parse (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [msgp_pkg::BYTE_W-1:0]  in_byte,
	input  logic                         in_eom,
	input  logic [msgp_pkg::CFG_W-1:0]   row_tag,
	input  logic [msgp_pkg::CFG_W-1:0]   msg_type,
	input  logic                         room,
	output msgp_pkg::push_t              push
);
	import msgp_pkg::*;

	// Input register.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              eom_s1;

	// Parse state.
	phase_t        phase_q;
	logic [3:0]    bc_q;
	logic [63:0]   acc_q;
	logic [31:0]   total_q;
	logic [2:0]    fidx_q;
	logic [7:0]    left_q;
	logic          sf_q;

	// Next state and step bookkeeping.
	phase_t        phase_d;
	logic [3:0]    bc_d;
	logic [63:0]   acc_d;
	logic [31:0]   total_d;
	logic [2:0]    fidx_d;
	logic [7:0]    left_d;
	logic          sf_d;
	logic [63:0]   acc_n;
	logic          fire;
	logic [1:0]    n;
	res_t          slot [2];
	logic          nf;
	logic          fl;
	logic [ERR_W-1:0] fcode;
	logic          adone;
	phase_t        aph;
	logic [31:0]   acount;
	logic          idone;
	phase_t        iph;
	logic [63:0]   ival;
	logic          sstart;
	logic [7:0]    slen;
	logic [3:0]    nidx;
	logic [KIND_W-1:0] id_kind;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;
	assign acc_n    = {acc_q[55:0], byte_s1};
	assign id_kind  = fidx_q - 3'd1;

	// Input register: a new byte enters whenever the current one moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eom_s1  <= in_eom;
		end
	end

	// Parse state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ENV_HDR;
			bc_q    <= '0;
			acc_q   <= '0;
			total_q <= '0;
			fidx_q  <= '0;
			left_q  <= '0;
			sf_q    <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			bc_q    <= bc_d;
			acc_q   <= acc_d;
			total_q <= total_d;
			fidx_q  <= fidx_d;
			left_q  <= left_d;
			sf_q    <= sf_d;
		end
	end

	// One byte of parsing: the phase step, then the shared follow-up actions.
	always_comb begin
		phase_d = phase_q;
		bc_d    = bc_q;
		acc_d   = acc_q;
		total_d = total_q;
		fidx_d  = fidx_q;
		left_d  = left_q;
		sf_d    = sf_q;
		n       = 2'd0;
		slot[0] = mk_res(KIND_STATUS, '0, 1'b0, 1'b0, ERR_OK);
		slot[1] = mk_res(KIND_STATUS, '0, 1'b0, 1'b0, ERR_OK);
		nf      = 1'b0;
		fl      = 1'b0;
		fcode   = ERR_OK;
		adone   = 1'b0;
		aph     = PH_ENV_HDR;
		acount  = '0;
		idone   = 1'b0;
		iph     = PH_TYPE_TAG;
		ival    = '0;
		sstart  = 1'b0;
		slen    = '0;
		nidx    = '0;

		case (phase_q)
			PH_ENV_HDR, PH_ROWS_HDR, PH_ROW_HDR: begin
				if (byte_s1[7:4] == NIB_FIXARR) begin
					adone  = 1'b1;
					aph    = phase_q;
					acount = {28'd0, byte_s1[3:0]};
				end else if (byte_s1 == B_ARR16 || byte_s1 == B_ARR32) begin
					bc_d  = (byte_s1 == B_ARR16) ? 4'd2 : 4'd4;
					acc_d = '0;
					case (phase_q)
						PH_ENV_HDR:  phase_d = PH_ENV_LEN;
						PH_ROWS_HDR: phase_d = PH_ROWS_LEN;
						default:     phase_d = PH_ROW_LEN;
					endcase
				end else begin
					fl    = 1'b1;
					fcode = ERR_ARR_HDR;
				end
			end
			PH_ENV_LEN, PH_ROWS_LEN, PH_ROW_LEN: begin
				acc_d = acc_n;
				bc_d  = bc_q - 4'd1;
				if (bc_d == 4'd0) begin
					adone  = 1'b1;
					acount = acc_n[31:0];
					case (phase_q)
						PH_ENV_LEN:  aph = PH_ENV_HDR;
						PH_ROWS_LEN: aph = PH_ROWS_HDR;
						default:     aph = PH_ROW_HDR;
					endcase
				end
			end
			PH_TYPE_TAG, PH_TAG_TAG, PH_FOL_TAG: begin
				if (!byte_s1[7]) begin
					idone = 1'b1;
					iph   = phase_q;
					ival  = {56'd0, byte_s1};
				end else begin
					sf_d = 1'b0;
					if (byte_s1 == B_UINT64 || byte_s1 == B_INT64 ||
							byte_s1 == B_UINT32 || byte_s1 == B_INT32) begin
						bc_d  = (byte_s1 == B_UINT64 || byte_s1 == B_INT64) ? 4'd8 : 4'd4;
						sf_d  = (byte_s1 == B_INT32);
						acc_d = '0;
						case (phase_q)
							PH_TYPE_TAG: phase_d = PH_TYPE_VAL;
							PH_TAG_TAG:  phase_d = PH_TAG_VAL;
							default:     phase_d = PH_FOL_VAL;
						endcase
					end else begin
						fl    = 1'b1;
						fcode = ERR_INT_TAG;
					end
				end
			end
			PH_TYPE_VAL, PH_TAG_VAL, PH_FOL_VAL: begin
				acc_d = acc_n;
				bc_d  = bc_q - 4'd1;
				if (bc_d == 4'd0) begin
					idone = 1'b1;
					ival  = acc_n;
					if (sf_q && acc_n[31]) begin
						ival[63:32] = '1;
					end
					case (phase_q)
						PH_TYPE_VAL: iph = PH_TYPE_TAG;
						PH_TAG_VAL:  iph = PH_TAG_TAG;
						default:     iph = PH_FOL_TAG;
					endcase
				end
			end
			PH_ID_TAG: begin
				if (byte_s1 == B_NIL) begin
					slot[n[0]] = mk_res(id_kind, '0, 1'b0, 1'b1, ERR_OK);
					n  = n + 2'd1;
					nf = 1'b1;
				end else if (byte_s1 == B_EXT16) begin
					phase_d = PH_ID_KIND;
				end else begin
					fl    = 1'b1;
					fcode = ERR_ID_TAG;
				end
			end
			PH_ID_KIND: begin
				if (byte_s1 != B_ID_KIND) begin
					fl    = 1'b1;
					fcode = ERR_ID_KIND;
				end else begin
					bc_d    = '0;
					acc_d   = '0;
					phase_d = PH_ID_BYTES;
				end
			end
			PH_ID_BYTES: begin
				acc_d = acc_n;
				if (bc_q == 4'd7) begin
					slot[n[0]] = mk_res(id_kind, acc_n, 1'b0, 1'b0, ERR_OK);
					n     = n + 2'd1;
					acc_d = '0;
				end else if (bc_q == 4'd15) begin
					slot[n[0]] = mk_res(id_kind, acc_n, 1'b1, 1'b0, ERR_OK);
					n     = n + 2'd1;
					acc_d = '0;
					nf    = 1'b1;
				end
				bc_d = bc_q + 4'd1;
			end
			PH_STR_TAG: begin
				if (byte_s1[7:5] == TOP_FIXSTR) begin
					sstart = 1'b1;
					slen   = {3'd0, byte_s1[4:0]};
				end else if (byte_s1 == B_STR8 || byte_s1 == B_BIN8) begin
					phase_d = PH_STR_LEN;
				end else begin
					fl    = 1'b1;
					fcode = ERR_STR_TAG;
				end
			end
			PH_STR_LEN: begin
				sstart = 1'b1;
				slen   = byte_s1;
			end
			PH_STR_BYTES: begin
				slot[n[0]] = mk_res(KIND_NOTE, {56'd0, byte_s1}, 1'b0, 1'b0, ERR_OK);
				n      = n + 2'd1;
				left_d = left_q - 8'd1;
				if (left_d == 8'd0) begin
					nf = 1'b1;
				end
			end
			default: begin
				// Done or failed: bytes are ignored until the end of the message.
			end
		endcase

		// A string header announces its length, then its bytes or the next field.
		if (sstart) begin
			slot[n[0]] = mk_res(KIND_NOTE_LEN, {56'd0, slen}, 1'b0, 1'b0, ERR_OK);
			n = n + 2'd1;
			if (slen == 8'd0) begin
				nf = 1'b1;
			end else begin
				left_d  = slen;
				phase_d = PH_STR_BYTES;
			end
		end

		// An array count is complete.
		if (adone) begin
			case (aph)
				PH_ENV_HDR: begin
					if (acount != ENV_COUNT) begin
						fl    = 1'b1;
						fcode = ERR_ENVELOPE;
					end else begin
						phase_d = PH_TYPE_TAG;
					end
				end
				PH_ROWS_HDR: begin
					if (acount == '0) begin
						fl    = 1'b1;
						fcode = ERR_NO_ROWS;
					end else begin
						phase_d = PH_ROW_HDR;
					end
				end
				default: begin
					if (acount < MIN_ROW_FIELDS) begin
						fl    = 1'b1;
						fcode = ERR_FEW_FLDS;
					end else begin
						total_d = acount;
						fidx_d  = '0;
						phase_d = PH_TAG_TAG;
					end
				end
			endcase
		end

		// An integer is complete.
		if (idone) begin
			case (iph)
				PH_TYPE_TAG: begin
					if (ival != {56'd0, msg_type}) begin
						fl    = 1'b1;
						fcode = ERR_TYPE;
					end else begin
						phase_d = PH_ROWS_HDR;
					end
				end
				PH_TAG_TAG: begin
					if (ival != {56'd0, row_tag}) begin
						fl    = 1'b1;
						fcode = ERR_ROW_TAG;
					end else begin
						nf = 1'b1;
					end
				end
				default: begin
					slot[n[0]] = mk_res(KIND_FOLLOWS, ival, 1'b0, 1'b0, ERR_OK);
					n  = n + 2'd1;
					nf = 1'b1;
				end
			endcase
		end

		// Move to the next row field, or finish the row.
		if (nf) begin
			nidx = {1'b0, fidx_q} + 4'd1;
			if (nidx >= FIELD_LIMIT || {28'd0, nidx} >= total_q) begin
				if (n < 2'd2) begin
					slot[n[0]] = mk_res(KIND_STATUS, '0, 1'b0, 1'b0, ERR_OK);
					n = n + 2'd1;
				end
				phase_d = PH_DONE;
			end else begin
				fidx_d = nidx[2:0];
				if (nidx <= FIELD_LAST_ID) begin
					phase_d = PH_ID_TAG;
				end else if (nidx == FIELD_FOLLOWS) begin
					phase_d = PH_FOL_TAG;
				end else begin
					phase_d = PH_STR_TAG;
				end
			end
		end

		// A failed check reports once and parks the parser.
		if (fl) begin
			if (n < 2'd2) begin
				slot[n[0]] = mk_res(KIND_STATUS, '0, 1'b0, 1'b0, fcode);
				n = n + 2'd1;
			end
			phase_d = PH_ERR;
		end

		// End of message: report an unfinished parse, then start over.
		if (eom_s1) begin
			if (phase_d != PH_DONE && phase_d != PH_ERR && n < 2'd2) begin
				slot[n[0]] = mk_res(KIND_STATUS, '0, 1'b0, 1'b0, ERR_TRUNCATED);
				n = n + 2'd1;
			end
			phase_d = PH_ENV_HDR;
			bc_d    = '0;
			acc_d   = '0;
			total_d = '0;
			fidx_d  = '0;
			left_d  = '0;
			sf_d    = 1'b0;
		end

		// Mark the final result of this byte.
		if (n == 2'd1) begin
			slot[0].last = 1'b1;
		end else if (n == 2'd2) begin
			slot[1].last = 1'b1;
		end
	end

	assign push.cnt = fire ? n : 2'd0;
	assign push.r0  = slot[0];
	assign push.r1  = slot[1];

endmodule

@@ rtl/msgp_rq.sv @@
// ---------------------------------------------------------------------------
// MessagePack row parser result queue
// Four-entry queue that takes up to two results per cycle from the parser
// and presents one result per cycle on the output while out_ready is high.
// ---------------------------------------------------------------------------
module msgp_rq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  msgp_pkg::push_t                  push,
	output logic                             room,
	output logic [msgp_pkg::QLEVEL_W-1:0]    level,
	output logic                             out_valid,
	input  logic                             out_ready,
	output msgp_pkg::res_t                   out_res
);
	import msgp_pkg::*;

	res_t              mem [QDEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QLEVEL_W-1:0] level_q;
	logic              pop;

	assign out_valid = (level_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = mem[head_q];
	assign level     = level_q;
	// A byte may bring two results, so the parser waits for two free entries.
	assign room      = (level_q <= QLEVEL_W'(QDEPTH - 2));

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + QPTR_W'(1);
			end
			tail_q  <= tail_q + QPTR_W'(push.cnt);
			level_q <= level_q + QLEVEL_W'(push.cnt) - QLEVEL_W'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[tail_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem[tail_q + QPTR_W'(1)] <= push.r1;
		end
	end

endmodule

@@ rtl/msgpack_transaction_row_parser_top.sv @@
// ---------------------------------------------------------------------------
// MessagePack transaction row parser
// Decodes a MessagePack envelope and the first transaction row of each
// message, one byte per item, into id, integer, note and status results.
// ---------------------------------------------------------------------------
//  channel   | direction | item
//  s_*       | in        | one message byte, tlast on the final byte
//  m_*       | out       | one decoded result, tlast on the last one of a byte
//  cfg_*     | in        | register write: 0 row tag, 1 message type
//
// One byte is accepted per cycle unless input stalls. Each byte is held in
// an input register, and its results then enter a four-entry result queue.
// A byte gives at most two results, which leave that queue at one per cycle
// while m_tready is high. Input stalls only while the queue has fewer than
// two free entries. Reset is asynchronous and returns the parse state and the
// registers to their defaults; tlast on input also resets the parse state,
// while the registers keep their values.
// ---------------------------------------------------------------------------
`include "msgpack_transaction_row_parser_top_defines.svh"

module msgpack_transaction_row_parser_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [msgp_pkg::BYTE_W-1:0]         s_tdata,  // [7:0] data_byte
	input  logic                                s_tlast,  // end_of_message
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [63:0] field_value, [67:64] error_code, [71:68] zero
	output logic [msgp_pkg::TDATA_W-1:0]        m_tdata,
	// [2:0] field_kind, [3] id_half, [4] is_nil
	output logic [msgp_pkg::TUSER_W-1:0]        m_tuser,
	output logic                                m_tlast,  // last_of_run
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [msgp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [msgp_pkg::CFG_W-1:0]          cfg_data
);
	import msgp_pkg::*;

	logic [CFG_W-1:0]    row_tag_q;
	logic [CFG_W-1:0]    msg_type_q;
	push_t               push;
	logic                room;
	logic [QLEVEL_W-1:0] level;
	res_t                out_res;

	// Configuration registers, always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_tag_q  <= ROW_TAG_RESET;
			msg_type_q <= MSG_TYPE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROW_TAG:  row_tag_q  <= cfg_data;
				CFG_MSG_TYPE: msg_type_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Byte stage.
	msgp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_eom   (s_tlast),
		.row_tag  (row_tag_q),
		.msg_type (msg_type_q),
		.room     (room),
		.push     (push)
	);

	// Result queue.
	msgp_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.level     (level),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Output packing.
	assign m_tdata = {4'd0, out_res.err, out_res.value};
	assign m_tuser = {out_res.nil, out_res.half, out_res.kind};
	assign m_tlast = out_res.last;

	// Checks.
	`MSGP_ASSERT_ALWAYS(a_level_max, level <= QLEVEL_W'(QDEPTH), "result queue overfilled")
	`MSGP_ASSERT_IMPLY(a_push_room, push.cnt != 2'd0, room,
		"results pushed without two free entries")
	`MSGP_ASSERT_IMPLY(a_status_last, m_tvalid && m_tuser[2:0] == KIND_STATUS, m_tlast,
		"status result is not the last of its byte")
	`MSGP_ASSERT_IMPLY(a_err_status, m_tvalid && m_tuser[2:0] != KIND_STATUS,
		m_tdata[67:64] == ERR_OK, "error code on a non-status result")

endmodule
